// ===== sv/tfvh_pkg.sv =====
// Shared types, constants and helper functions for the track face vote histogram.
// Used by tfvh_key_table, tfvh_vote_bins and track_face_vote_histogram_top.
// No dependencies.
package tfvh_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_TRACKS_DEF = 64;
    localparam int FACE_IDS_DEF   = 30;

    // Candidates carried per item and how many of them are counted
    localparam int CAND_FIELDS    = 3;
    localparam int VOTES_PER_BODY = 3;
    localparam int NUM_VOTES      = (VOTES_PER_BODY < CAND_FIELDS) ? VOTES_PER_BODY
                                                                   : CAND_FIELDS;

    // Field widths
    localparam int KEY_W    = 64;
    localparam int FACE_W   = 5;
    localparam int CONF_W   = 10;
    localparam int WEIGHT_W = 4;
    localparam int SCORE_W  = 16;
    localparam int TN_W     = 7;
    localparam int ADD_W    = 8;

    // Divide by 100 as multiply by 41 and shift by 12 (exact for 10-bit inputs)
    localparam int WEIGHT_MUL   = 41;
    localparam int WEIGHT_SHIFT = 12;

    localparam logic [SCORE_W-1:0] BIN_MAX = {SCORE_W{1'b1}};

    typedef enum logic [2:0] {
        T_IDLE,
        T_LOOKUP,
        T_BASE,
        T_VOTE,
        T_PUSH
    } tfvh_top_state_t;

    typedef enum logic {
        K_IDLE,
        K_SCAN
    } tfvh_key_state_t;

    typedef enum logic {
        V_IDLE,
        V_RUN
    } tfvh_vote_state_t;

    // Lookup outcome, valid for one cycle when done is set
    typedef struct packed {
        logic done;
        logic is_new;
        logic full;
    } lkp_status_t;

    // Vote weight: confidence divided by 100, rounded down
    function automatic logic [WEIGHT_W-1:0] conf_weight(input logic [CONF_W-1:0] conf);
        logic [15:0] prod;
        prod = 16'(conf) * 16'(WEIGHT_MUL);
        return prod[WEIGHT_SHIFT +: WEIGHT_W];
    endfunction

endpackage

// ===== sv/tfvh_key_table.sv =====
// Tracking id key table: key memory, sequential search and dense allocation.
// Depends on tfvh_pkg.
module tfvh_key_table #(
    parameter int MAX_TRACKS = tfvh_pkg::MAX_TRACKS_DEF,
    localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tfvh_pkg::KEY_W-1:0]  key,
    output logic [IDX_W-1:0]            slot,
    output tfvh_pkg::lkp_status_t       status
);
    import tfvh_pkg::*;

    localparam int CNT_W = $clog2(MAX_TRACKS + 1);

    logic [KEY_W-1:0]   key_mem [MAX_TRACKS];
    logic [KEY_W-1:0]   rdata_reg;

    tfvh_key_state_t    state_reg, state_next;
    logic [CNT_W-1:0]   alloc_reg, alloc_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    lkp_status_t        status_reg, status_next;

    logic               rd_en, wr_en;
    logic [IDX_W-1:0]   rd_addr, wr_addr;
    logic               hit;

    // Scan allocated entries one read a cycle; compare each entry in the cycle after its read
    always_comb
    begin
        state_next     = state_reg;
        alloc_next     = alloc_reg;
        scan_next      = scan_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        slot_next      = slot_reg;
        status_next    = '0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        rd_addr        = scan_reg[IDX_W-1:0];
        wr_addr        = alloc_reg[IDX_W-1:0];
        hit            = cmp_valid_reg && (rdata_reg == key);

        unique case (state_reg)
            K_IDLE:
            begin
                if (start)
                begin
                    scan_next      = '0;
                    cmp_valid_next = 1'b0;
                    state_next     = K_SCAN;
                end
            end
            K_SCAN:
            begin
                if (hit)
                begin
                    slot_next          = cmp_idx_reg;
                    status_next.done   = 1'b1;
                    cmp_valid_next     = 1'b0;
                    state_next         = K_IDLE;
                end
                else if (scan_reg < alloc_reg)
                begin
                    rd_en          = 1'b1;
                    cmp_idx_next   = scan_reg[IDX_W-1:0];
                    cmp_valid_next = 1'b1;
                    scan_next      = scan_reg + CNT_W'(1);
                end
                else
                begin
                    // Miss: allocate the next entry or report a full table
                    cmp_valid_next   = 1'b0;
                    state_next       = K_IDLE;
                    status_next.done = 1'b1;
                    if (alloc_reg == CNT_W'(MAX_TRACKS))
                    begin
                        status_next.full = 1'b1;
                    end
                    else
                    begin
                        wr_en              = 1'b1;
                        slot_next          = alloc_reg[IDX_W-1:0];
                        status_next.is_new = 1'b1;
                        alloc_next         = alloc_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = K_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= K_IDLE;
            alloc_reg     <= '0;
            scan_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            status_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            alloc_reg     <= alloc_next;
            scan_reg      <= scan_next;
            cmp_valid_reg <= cmp_valid_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        slot_reg    <= slot_next;
    end

    // Key memory, one registered read port and one write port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= key_mem[rd_addr];
        end
        if (wr_en)
        begin
            key_mem[wr_addr] <= key;
        end
    end

    assign slot   = slot_reg;
    assign status = status_reg;

endmodule

// ===== sv/tfvh_vote_bins.sv =====
// Vote bin memory with one read-modify-write pass over a track's row,
// adding the item's votes and finding the largest bin. Depends on tfvh_pkg.
module tfvh_vote_bins #(
    parameter int MAX_TRACKS = tfvh_pkg::MAX_TRACKS_DEF,
    parameter int FACE_IDS   = tfvh_pkg::FACE_IDS_DEF,
    localparam int AW    = $clog2(MAX_TRACKS * FACE_IDS),
    localparam int BIN_W = $clog2(FACE_IDS)
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               start,
    input  logic [AW-1:0]                                      row_base,
    input  logic                                               is_new,
    input  logic [tfvh_pkg::CAND_FIELDS-1:0][tfvh_pkg::FACE_W-1:0]   face_ids,
    input  logic [tfvh_pkg::CAND_FIELDS-1:0][tfvh_pkg::WEIGHT_W-1:0] weights,
    output logic                                               done,
    output logic [BIN_W-1:0]                                   best_bin,
    output logic [tfvh_pkg::SCORE_W-1:0]                       best_score
);
    import tfvh_pkg::*;

    localparam int DEPTH  = MAX_TRACKS * FACE_IDS;
    localparam int BIN_CW = $clog2(FACE_IDS + 1);
    localparam int CMP_W  = (BIN_W > FACE_W) ? BIN_W : FACE_W;

    logic [SCORE_W-1:0]  bin_mem [DEPTH];
    logic [SCORE_W-1:0]  rdata_reg;

    tfvh_vote_state_t    state_reg, state_next;
    logic [BIN_CW-1:0]   rd_bin_reg, rd_bin_next;
    logic                dat_valid_reg, dat_valid_next;
    logic [BIN_W-1:0]    dat_bin_reg, dat_bin_next;
    logic [AW-1:0]       base_reg, base_next;
    logic                is_new_reg, is_new_next;
    logic [BIN_W-1:0]    best_bin_reg, best_bin_next;
    logic [SCORE_W-1:0]  best_val_reg, best_val_next;
    logic                done_reg, done_next;

    logic                rd_en, wr_en;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic [SCORE_W-1:0]  old_val, new_val;
    logic [ADD_W-1:0]    add_val;
    logic [SCORE_W:0]    sum_val;

    // Issue one bin read a cycle; update and write back the bin read last cycle
    always_comb
    begin
        state_next     = state_reg;
        rd_bin_next    = rd_bin_reg;
        dat_valid_next = 1'b0;
        dat_bin_next   = dat_bin_reg;
        base_next      = base_reg;
        is_new_next    = is_new_reg;
        best_bin_next  = best_bin_reg;
        best_val_next  = best_val_reg;
        done_next      = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        rd_addr        = base_reg + AW'(rd_bin_reg[BIN_W-1:0]);
        wr_addr        = base_reg + AW'(dat_bin_reg);

        // Sum the weights of the counted votes that name this bin
        add_val = '0;
        for (int v = 0; v < NUM_VOTES; v++)
        begin
            if (CMP_W'(face_ids[v]) == CMP_W'(dat_bin_reg))
            begin
                add_val = add_val + ADD_W'(weights[v]);
            end
        end
        // A freshly allocated row reads as cleared
        old_val = is_new_reg ? '0 : rdata_reg;
        sum_val = (SCORE_W + 1)'(old_val) + (SCORE_W + 1)'(add_val);
        new_val = sum_val[SCORE_W] ? BIN_MAX : sum_val[SCORE_W-1:0];

        unique case (state_reg)
            V_IDLE:
            begin
                if (start)
                begin
                    base_next   = row_base;
                    is_new_next = is_new;
                    rd_bin_next = '0;
                    state_next  = V_RUN;
                end
            end
            V_RUN:
            begin
                if (rd_bin_reg < BIN_CW'(FACE_IDS))
                begin
                    rd_en          = 1'b1;
                    dat_valid_next = 1'b1;
                    dat_bin_next   = rd_bin_reg[BIN_W-1:0];
                    rd_bin_next    = rd_bin_reg + BIN_CW'(1);
                end
                if (dat_valid_reg)
                begin
                    wr_en = 1'b1;
                    // Strictly greater keeps the lowest bin on ties
                    if (dat_bin_reg == '0 || new_val > best_val_reg)
                    begin
                        best_bin_next = dat_bin_reg;
                        best_val_next = new_val;
                    end
                    if (dat_bin_reg == BIN_W'(FACE_IDS - 1))
                    begin
                        done_next  = 1'b1;
                        state_next = V_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = V_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= V_IDLE;
            dat_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dat_valid_reg <= dat_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_bin_reg   <= rd_bin_next;
        dat_bin_reg  <= dat_bin_next;
        base_reg     <= base_next;
        is_new_reg   <= is_new_next;
        best_bin_reg <= best_bin_next;
        best_val_reg <= best_val_next;
    end

    // Bin memory: read and write addresses differ in every cycle of the pass
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= bin_mem[rd_addr];
        end
        if (wr_en)
        begin
            bin_mem[wr_addr] <= new_val;
        end
    end

    assign done       = done_reg;
    assign best_bin   = best_bin_reg;
    assign best_score = best_val_reg;

endmodule

// ===== sv/track_face_vote_histogram_top.sv =====
// Top level of the track face vote histogram: stream ports, item sequencing
// and result register. Depends on tfvh_pkg, tfvh_key_table and tfvh_vote_bins.
//
// Each transfer carries a body tracking id and three face candidates. The id
// is searched in a key table of MAX_TRACKS entries; a new id takes the next
// free track number from 1, and a new id that finds the table full returns
// track_number 0 with the table_full flag and casts no vote. Each candidate
// with a face id below FACE_IDS adds its confidence divided by 100 to the
// track's bin (saturating at 65535), and the result gives the track number,
// the largest bin (lowest id on ties) and its count. A zero tracking id is
// taken and produces no result. Otherwise the key memory is read one entry
// per cycle until a match (through every allocated entry for a new body),
// then the track's row of bins goes through one read-modify-write per cycle
// on the bin memory. Items are handled one at a time; the next item is taken
// while the last result waits in the output register. Memories start
// undefined and need no clearing pass: a new track's row is treated as zero
// during its first pass.
module track_face_vote_histogram_top #(
    parameter int MAX_TRACKS = tfvh_pkg::MAX_TRACKS_DEF,
    parameter int FACE_IDS   = tfvh_pkg::FACE_IDS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [63:0] body_tracking_id, [68:64] face_id_a, [78:69] face_conf_a,
    // [83:79] face_id_b, [93:84] face_conf_b, [98:94] face_id_c,
    // [108:99] face_conf_c, [111:109] zero
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [6:0] track_number, [11:7] best_face, [27:12] best_score, [31:28] zero
    output logic [31:0]  m_axis_tdata,
    // [0] table_full
    output logic         m_axis_tuser
);
    import tfvh_pkg::*;

    localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int AW    = $clog2(MAX_TRACKS * FACE_IDS);
    localparam int BIN_W = $clog2(FACE_IDS);
    localparam int TNS_W = IDX_W + TN_W + 1;
    localparam int BFS_W = BIN_W + FACE_W;

    tfvh_top_state_t    state_reg, state_next;
    logic [KEY_W-1:0]   key_reg;
    logic [CAND_FIELDS-1:0][FACE_W-1:0]   face_reg;
    logic [CAND_FIELDS-1:0][WEIGHT_W-1:0] weight_reg;
    logic               is_new_reg, is_new_next;
    logic               full_reg, full_next;

    logic               out_valid_reg, out_valid_next;
    logic [TN_W-1:0]    out_tn_reg, out_tn_next;
    logic [FACE_W-1:0]  out_face_reg, out_face_next;
    logic [SCORE_W-1:0] out_score_reg, out_score_next;
    logic               out_full_reg, out_full_next;

    logic               in_xfer;
    logic               lkp_start;
    logic [IDX_W-1:0]   slot;
    lkp_status_t        lkp_status;
    logic               vote_start;
    logic [AW-1:0]      row_base;
    logic               vote_done;
    logic [BIN_W-1:0]   best_bin;
    logic [SCORE_W-1:0] best_score;
    logic [TNS_W-1:0]   tn_wide;
    logic [BFS_W-1:0]   bf_wide;

    assign s_axis_tready = (state_reg == T_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign lkp_start     = in_xfer && (s_axis_tdata[63:0] != '0);
    assign row_base      = AW'(AW'(slot) * AW'(FACE_IDS));
    assign tn_wide       = TNS_W'(slot) + TNS_W'(1);
    assign bf_wide       = BFS_W'(best_bin);

    // Hold the item fields and its vote weights for the whole item
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            key_reg       <= s_axis_tdata[63:0];
            face_reg[0]   <= s_axis_tdata[68:64];
            weight_reg[0] <= conf_weight(s_axis_tdata[78:69]);
            face_reg[1]   <= s_axis_tdata[83:79];
            weight_reg[1] <= conf_weight(s_axis_tdata[93:84]);
            face_reg[2]   <= s_axis_tdata[98:94];
            weight_reg[2] <= conf_weight(s_axis_tdata[108:99]);
        end
    end

    // Sequence lookup, row base, vote pass and result transfer
    always_comb
    begin
        state_next     = state_reg;
        is_new_next    = is_new_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg;
        out_tn_next    = out_tn_reg;
        out_face_next  = out_face_reg;
        out_score_next = out_score_reg;
        out_full_next  = out_full_reg;
        vote_start     = 1'b0;

        // Drop the output once the downstream side takes it
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            T_IDLE:
            begin
                if (lkp_start)
                begin
                    state_next = T_LOOKUP;
                end
            end
            T_LOOKUP:
            begin
                if (lkp_status.done)
                begin
                    is_new_next = lkp_status.is_new;
                    full_next   = lkp_status.full;
                    state_next  = lkp_status.full ? T_PUSH : T_BASE;
                end
            end
            T_BASE:
            begin
                vote_start = 1'b1;
                state_next = T_VOTE;
            end
            T_VOTE:
            begin
                if (vote_done)
                begin
                    state_next = T_PUSH;
                end
            end
            T_PUSH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_full_next  = full_reg;
                    out_tn_next    = full_reg ? '0 : tn_wide[TN_W-1:0];
                    out_face_next  = full_reg ? '0 : bf_wide[FACE_W-1:0];
                    out_score_next = full_reg ? '0 : best_score;
                    state_next     = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_new_reg    <= is_new_next;
        full_reg      <= full_next;
        out_tn_reg    <= out_tn_next;
        out_face_reg  <= out_face_next;
        out_score_reg <= out_score_next;
        out_full_reg  <= out_full_next;
    end

    tfvh_key_table #(
        .MAX_TRACKS (MAX_TRACKS)
    ) u_key_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lkp_start),
        .key    (key_reg),
        .slot   (slot),
        .status (lkp_status)
    );

    tfvh_vote_bins #(
        .MAX_TRACKS (MAX_TRACKS),
        .FACE_IDS   (FACE_IDS)
    ) u_vote_bins (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (vote_start),
        .row_base   (row_base),
        .is_new     (is_new_reg),
        .face_ids   (face_reg),
        .weights    (weight_reg),
        .done       (vote_done),
        .best_bin   (best_bin),
        .best_score (best_score)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_score_reg, out_face_reg, out_tn_reg};
    assign m_axis_tuser  = out_full_reg;

endmodule
